// File: src/svang_pkg.sv
package svang_pkg;

  localparam int CompW     = 16;
  localparam int AngleW    = 15;
  localparam int SqW       = 31;
  localparam int NormW     = 32;
  localparam int DotW      = 33;
  localparam int CrossW    = 33;
  localparam int TriPW     = CompW + CrossW;
  localparam int TriW      = TriPW + 2;
  localparam int ProdW     = 64;
  localparam int RootW     = 32;
  localparam int NormSteps = 5;
  localparam int CosFrac   = 30;
  localparam int CosW      = 31;
  localparam int DivNumW   = 2 * RootW - 1;
  localparam int RadW      = 62;
  localparam int CordW     = 33;
  localparam int ZW        = 20;
  localparam int ZcW       = 18;
  localparam int AtanW     = 17;
  localparam int CordSteps = 17;

  localparam logic [ZcW-1:0]           PI_Q16   = 18'd205887;
  localparam logic [CosW-1:0]          ONE_Q30  = 31'h4000_0000;
  localparam logic [RadW-1:0]          ONE_Q60  = 62'h1000_0000_0000_0000;
  localparam logic signed [AngleW-1:0] AngleMax = 15'sd12868;

  localparam logic [AtanW-1:0] ATAN_TAB [CordSteps] = '{
    17'd51472, 17'd30385, 17'd16055, 17'd8150, 17'd4091, 17'd2047,
    17'd1024, 17'd512, 17'd256, 17'd128, 17'd64, 17'd32, 17'd16,
    17'd8, 17'd4, 17'd2, 17'd1
  };

  typedef struct packed {
    logic zero;
    logic neg_dot;
    logic neg_tri;
  } flags_t;

  localparam int FlagsW = $bits(flags_t);

  function automatic logic signed [2*CompW-1:0] mul16(input logic signed [CompW-1:0] a,
                                                      input logic signed [CompW-1:0] b);
    return (2*CompW)'(a) * (2*CompW)'(b);
  endfunction

endpackage

// File: src/svang_sqrt.sv
module svang_sqrt #(
  parameter int W    = 64,
  parameter int TagW = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_vld,
  input  logic [W-1:0]    in_rad,
  input  logic [TagW-1:0] in_tag,
  output logic            out_vld,
  output logic [W/2-1:0]  out_root,
  output logic [TagW-1:0] out_tag
);

  localparam int N = W / 2;

  logic [W-1:0]    v_r   [N];
  logic [W-1:0]    r_r   [N];
  logic [TagW-1:0] tag_r [N];
  logic            vld_r [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam logic [W-1:0] BitV = {{(W-1){1'b0}}, 1'b1} << (W - 2 - 2 * k);
    logic [W-1:0]    v_i, r_i, v_nxt, r_nxt;
    logic [TagW-1:0] tag_i;
    logic            vld_i;
    logic [W:0]      trial, diff;

    if (k == 0) begin : g_head
      assign v_i   = in_rad;
      assign r_i   = '0;
      assign tag_i = in_tag;
      assign vld_i = in_vld;
    end else begin : g_body
      assign v_i   = v_r[k-1];
      assign r_i   = r_r[k-1];
      assign tag_i = tag_r[k-1];
      assign vld_i = vld_r[k-1];
    end

    assign trial = {1'b0, r_i} + {1'b0, BitV};
    assign diff  = {1'b0, v_i} - trial;

    always_comb begin
      if ({1'b0, v_i} >= trial) begin
        v_nxt = diff[W-1:0];
        r_nxt = (r_i >> 1) + BitV;
      end else begin
        v_nxt = v_i;
        r_nxt = r_i >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        v_r[k]   <= v_nxt;
        r_r[k]   <= r_nxt;
        tag_r[k] <= tag_i;
      end
    end
  end

  assign out_vld  = vld_r[N-1];
  assign out_root = r_r[N-1][N-1:0];
  assign out_tag  = tag_r[N-1];

endmodule

// File: src/svang_div.sv
module svang_div
  import svang_pkg::*;
#(
  parameter int TagW = 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  logic [DivNumW-1:0] in_num,
  input  logic [RootW-1:0]   in_den,
  input  logic [TagW-1:0]    in_tag,
  output logic               out_vld,
  output logic [RootW-1:0]   out_quo,
  output logic [TagW-1:0]    out_tag
);

  localparam int N = RootW;

  logic [RootW-1:0] rem_r [N];
  logic [RootW-1:0] low_r [N];
  logic [RootW-1:0] den_r [N];
  logic [RootW-1:0] quo_r [N];
  logic [TagW-1:0]  tag_r [N];
  logic             vld_r [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [RootW-1:0] rem_i, low_i, den_i, quo_i, rem_nxt;
    logic [TagW-1:0]  tag_i;
    logic             vld_i, qbit;
    logic [RootW:0]   sh, diff;

    if (k == 0) begin : g_head
      assign rem_i = {1'b0, in_num[DivNumW-1:RootW]};
      assign low_i = in_num[RootW-1:0];
      assign den_i = in_den;
      assign quo_i = '0;
      assign tag_i = in_tag;
      assign vld_i = in_vld;
    end else begin : g_body
      assign rem_i = rem_r[k-1];
      assign low_i = low_r[k-1];
      assign den_i = den_r[k-1];
      assign quo_i = quo_r[k-1];
      assign tag_i = tag_r[k-1];
      assign vld_i = vld_r[k-1];
    end

    assign sh   = {rem_i, low_i[RootW-1]};
    assign diff = sh - {1'b0, den_i};

    always_comb begin
      if (sh >= {1'b0, den_i}) begin
        rem_nxt = diff[RootW-1:0];
        qbit    = 1'b1;
      end else begin
        rem_nxt = sh[RootW-1:0];
        qbit    = 1'b0;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        low_r[k] <= {low_i[RootW-2:0], 1'b0};
        den_r[k] <= den_i;
        quo_r[k] <= {quo_i[RootW-2:0], qbit};
        tag_r[k] <= tag_i;
      end
    end
  end

  assign out_vld = vld_r[N-1];
  assign out_quo = quo_r[N-1];
  assign out_tag = tag_r[N-1];

endmodule

// File: src/svang_cordic.sv
module svang_cordic
  import svang_pkg::*;
#(
  parameter int TagW = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_vld,
  input  logic [CosW-1:0]      in_cos,
  input  logic [CosW-1:0]      in_sin,
  input  logic [TagW-1:0]      in_tag,
  output logic                 out_vld,
  output logic signed [ZW-1:0] out_z,
  output logic [TagW-1:0]      out_tag
);

  localparam int N = CordSteps;

  logic signed [CordW-1:0] x_r   [N];
  logic signed [CordW-1:0] y_r   [N];
  logic signed [ZW-1:0]    z_r   [N];
  logic [TagW-1:0]         tag_r [N];
  logic                    vld_r [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic signed [CordW-1:0] x_i, y_i, dx, dy, x_nxt, y_nxt;
    logic signed [ZW-1:0]    z_i, z_nxt, da;
    logic [TagW-1:0]         tag_i;
    logic                    vld_i;

    if (k == 0) begin : g_head
      assign x_i   = $signed({2'b00, in_cos});
      assign y_i   = $signed({2'b00, in_sin});
      assign z_i   = '0;
      assign tag_i = in_tag;
      assign vld_i = in_vld;
    end else begin : g_body
      assign x_i   = x_r[k-1];
      assign y_i   = y_r[k-1];
      assign z_i   = z_r[k-1];
      assign tag_i = tag_r[k-1];
      assign vld_i = vld_r[k-1];
    end

    assign dx = y_i >>> k;
    assign dy = x_i >>> k;
    assign da = $signed({{(ZW-AtanW){1'b0}}, ATAN_TAB[k]});

    always_comb begin
      if (y_i > 0) begin
        x_nxt = x_i + dx;
        y_nxt = y_i - dy;
        z_nxt = z_i + da;
      end else begin
        x_nxt = x_i - dx;
        y_nxt = y_i + dy;
        z_nxt = z_i - da;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[k]   <= x_nxt;
        y_r[k]   <= y_nxt;
        z_r[k]   <= z_nxt;
        tag_r[k] <= tag_i;
      end
    end
  end

  assign out_vld = vld_r[N-1];
  assign out_z   = z_r[N-1];
  assign out_tag = tag_r[N-1];

endmodule

// File: src/signed_vector_angle.sv
// Signed angle from the first vector to the second, Q3.12 radians, sign taken from the
// plane normal (negative only when normal . (first x second) < 0). Fully pipelined: one
// transaction is taken every cycle, the pipeline depth being set mostly by the two
// bit-per-stage square roots (32 and 31 stages), the bit-per-stage divider (32 stages)
// and the 17-stage CORDIC. When the result is not taken the whole pipeline holds.
// A zero-length vector gives zero_length = 1 and angle 0.
module signed_vector_angle
  import svang_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [CompW-1:0]  in_first_x,
  input  logic signed [CompW-1:0]  in_first_y,
  input  logic signed [CompW-1:0]  in_first_z,
  input  logic signed [CompW-1:0]  in_second_x,
  input  logic signed [CompW-1:0]  in_second_y,
  input  logic signed [CompW-1:0]  in_second_z,
  input  logic signed [CompW-1:0]  in_normal_x,
  input  logic signed [CompW-1:0]  in_normal_y,
  input  logic signed [CompW-1:0]  in_normal_z,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [AngleW-1:0] out_angle,
  output logic                     out_zero_length
);

  localparam int Sq1TagW = FlagsW + RootW;
  localparam int Sq2TagW = FlagsW + CosW;

  logic en;

  // stage 1: products
  logic                        s1_vld_r;
  logic [SqW-1:0]              s1_sq_r [6];
  logic signed [2*CompW-1:0]   s1_dp_r [3];
  logic signed [2*CompW-1:0]   s1_cp_r [6];
  logic signed [CompW-1:0]     s1_n_r  [3];
  logic signed [2*CompW-1:0]   sq_p    [6];

  // stage 2: sums
  logic                        s2_vld_r;
  logic [NormW-1:0]            s2_na_r, s2_nb_r;
  logic signed [DotW-1:0]      s2_dot_r;
  logic signed [CrossW-1:0]    s2_c_r  [3];
  logic signed [CompW-1:0]     s2_n_r  [3];

  // stage 3
  logic                        s3_vld_r;
  logic [ProdW-1:0]            s3_prod_r;
  logic [RootW-1:0]            s3_mag_r;
  logic                        s3_zero_r, s3_neg_dot_r;
  logic signed [TriPW-1:0]     s3_t_r  [3];
  logic signed [DotW-1:0]      dot_abs;

  // stage 4
  logic                        s4_vld_r;
  logic [ProdW-1:0]            s4_prod_r;
  logic [RootW-1:0]            s4_mag_r;
  flags_t                      s4_flags_r;
  logic signed [TriW-1:0]      tri_sum;

  // normalise
  logic [ProdW-1:0]            nz_prod_r  [NormSteps];
  logic [RootW-1:0]            nz_mag_r   [NormSteps];
  flags_t                      nz_flags_r [NormSteps];
  logic                        nz_vld_r   [NormSteps];

  // first root
  logic                        sq1_vld;
  logic [RootW-1:0]            sq1_root;
  logic [Sq1TagW-1:0]          sq1_tag;
  flags_t                      sq1_flags;
  logic [RootW-1:0]            sq1_mag;

  logic                        dn_vld_r;
  logic [DivNumW-1:0]          dn_num_r;
  logic [RootW-1:0]            dn_den_r;
  flags_t                      dn_flags_r;

  logic                        dv_vld;
  logic [RootW-1:0]            dv_quo;
  flags_t                      dv_flags;

  logic                        cl_vld_r;
  logic [CosW-1:0]             cl_cos_r;
  flags_t                      cl_flags_r;

  logic                        sq_vld_r;
  logic [RadW-1:0]             sq_csq_r;
  logic [CosW-1:0]             sq_cos_r;
  flags_t                      sq_flags_r;

  logic                        rd_vld_r;
  logic [RadW-1:0]             rd_rad_r;
  logic [CosW-1:0]             rd_cos_r;
  flags_t                      rd_flags_r;

  logic                        sq2_vld;
  logic [CosW-1:0]             sq2_root;
  logic [Sq2TagW-1:0]          sq2_tag;
  flags_t                      sq2_flags;
  logic [CosW-1:0]             sq2_cos;

  logic                        cd_vld;
  logic signed [ZW-1:0]        cd_z;
  flags_t                      cd_flags;

  logic                        pz_vld_r;
  logic [ZcW-1:0]              pz_z_r;
  flags_t                      pz_flags_r;
  logic [ZcW-1:0]              zc, zf;

  logic                        out_valid_r;
  logic signed [AngleW-1:0]    out_angle_r;
  logic                        out_zero_r;
  logic [ZcW:0]                q_round;
  logic signed [AngleW-1:0]    q_mag;

  assign en       = out_ready | ~out_valid_r;
  assign in_ready = en;

  // ---------------- stage 1
  assign sq_p[0] = mul16(in_first_x, in_first_x);
  assign sq_p[1] = mul16(in_first_y, in_first_y);
  assign sq_p[2] = mul16(in_first_z, in_first_z);
  assign sq_p[3] = mul16(in_second_x, in_second_x);
  assign sq_p[4] = mul16(in_second_y, in_second_y);
  assign sq_p[5] = mul16(in_second_z, in_second_z);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_valid;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 6; i++) begin
        s1_sq_r[i] <= sq_p[i][SqW-1:0];
      end
      s1_dp_r[0] <= mul16(in_first_x, in_second_x);
      s1_dp_r[1] <= mul16(in_first_y, in_second_y);
      s1_dp_r[2] <= mul16(in_first_z, in_second_z);
      s1_cp_r[0] <= mul16(in_first_y, in_second_z);
      s1_cp_r[1] <= mul16(in_first_z, in_second_y);
      s1_cp_r[2] <= mul16(in_first_z, in_second_x);
      s1_cp_r[3] <= mul16(in_first_x, in_second_z);
      s1_cp_r[4] <= mul16(in_first_x, in_second_y);
      s1_cp_r[5] <= mul16(in_first_y, in_second_x);
      s1_n_r[0]  <= in_normal_x;
      s1_n_r[1]  <= in_normal_y;
      s1_n_r[2]  <= in_normal_z;
    end
  end

  // ---------------- stage 2
  always_ff @(posedge clk) begin
    if (en) begin
      s2_na_r  <= NormW'(s1_sq_r[0]) + NormW'(s1_sq_r[1]) + NormW'(s1_sq_r[2]);
      s2_nb_r  <= NormW'(s1_sq_r[3]) + NormW'(s1_sq_r[4]) + NormW'(s1_sq_r[5]);
      s2_dot_r <= DotW'(s1_dp_r[0]) + DotW'(s1_dp_r[1]) + DotW'(s1_dp_r[2]);
      for (int i = 0; i < 3; i++) begin
        s2_c_r[i] <= CrossW'(s1_cp_r[2*i]) - CrossW'(s1_cp_r[2*i+1]);
        s2_n_r[i] <= s1_n_r[i];
      end
    end
  end

  // ---------------- stage 3
  assign dot_abs = s2_dot_r[DotW-1] ? -s2_dot_r : s2_dot_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_prod_r    <= ProdW'(s2_na_r) * ProdW'(s2_nb_r);
      s3_mag_r     <= dot_abs[RootW-1:0];
      s3_zero_r    <= (s2_na_r == '0) || (s2_nb_r == '0);
      s3_neg_dot_r <= s2_dot_r[DotW-1];
      for (int i = 0; i < 3; i++) begin
        s3_t_r[i] <= TriPW'(s2_n_r[i]) * TriPW'(s2_c_r[i]);
      end
    end
  end

  // ---------------- stage 4
  assign tri_sum = TriW'(s3_t_r[0]) + TriW'(s3_t_r[1]) + TriW'(s3_t_r[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      s4_prod_r          <= s3_prod_r;
      s4_mag_r           <= s3_mag_r;
      s4_flags_r.zero    <= s3_zero_r;
      s4_flags_r.neg_dot <= s3_neg_dot_r;
      s4_flags_r.neg_tri <= tri_sum[TriW-1];
    end
  end

  // ---------------- normalise product to [2^62, 2^64) by even shifts
  for (genvar j = 0; j < NormSteps; j++) begin : g_norm
    localparam int Sh = (ProdW / 2) >> j;
    logic [ProdW-1:0] p_i;
    logic [RootW-1:0] m_i;
    flags_t           f_i;
    logic             v_i;

    if (j == 0) begin : g_head
      assign p_i = s4_prod_r;
      assign m_i = s4_mag_r;
      assign f_i = s4_flags_r;
      assign v_i = s4_vld_r;
    end else begin : g_body
      assign p_i = nz_prod_r[j-1];
      assign m_i = nz_mag_r[j-1];
      assign f_i = nz_flags_r[j-1];
      assign v_i = nz_vld_r[j-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        nz_vld_r[j] <= 1'b0;
      end else if (en) begin
        nz_vld_r[j] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nz_flags_r[j] <= f_i;
        if (p_i[ProdW-1 -: Sh] == '0) begin
          nz_prod_r[j] <= p_i << Sh;
          nz_mag_r[j]  <= m_i << (Sh / 2);
        end else begin
          nz_prod_r[j] <= p_i;
          nz_mag_r[j]  <= m_i;
        end
      end
    end
  end

  svang_sqrt #(
    .W    (ProdW),
    .TagW (Sq1TagW)
  ) u_sqrt_norm (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (nz_vld_r[NormSteps-1]),
    .in_rad   (nz_prod_r[NormSteps-1]),
    .in_tag   ({nz_flags_r[NormSteps-1], nz_mag_r[NormSteps-1]}),
    .out_vld  (sq1_vld),
    .out_root (sq1_root),
    .out_tag  (sq1_tag)
  );

  assign sq1_flags = flags_t'(sq1_tag[Sq1TagW-1 -: FlagsW]);
  assign sq1_mag   = sq1_tag[RootW-1:0];

  // ---------------- dividend with half-divisor rounding
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dn_vld_r <= 1'b0;
    end else if (en) begin
      dn_vld_r <= sq1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dn_num_r   <= DivNumW'({sq1_mag, {CosFrac{1'b0}}}) + DivNumW'(sq1_root >> 1);
      dn_den_r   <= sq1_root;
      dn_flags_r <= sq1_flags;
    end
  end

  svang_div #(
    .TagW (FlagsW)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (dn_vld_r),
    .in_num  (dn_num_r),
    .in_den  (dn_den_r),
    .in_tag  (dn_flags_r),
    .out_vld (dv_vld),
    .out_quo (dv_quo),
    .out_tag (dv_flags)
  );

  // ---------------- clamp, square, sine radicand
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cl_vld_r <= 1'b0;
      sq_vld_r <= 1'b0;
      rd_vld_r <= 1'b0;
    end else if (en) begin
      cl_vld_r <= dv_vld;
      sq_vld_r <= cl_vld_r;
      rd_vld_r <= sq_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cl_cos_r   <= (dv_quo > RootW'(ONE_Q30)) ? ONE_Q30 : dv_quo[CosW-1:0];
      cl_flags_r <= dv_flags;
      sq_csq_r   <= RadW'(cl_cos_r) * RadW'(cl_cos_r);
      sq_cos_r   <= cl_cos_r;
      sq_flags_r <= cl_flags_r;
      rd_rad_r   <= ONE_Q60 - sq_csq_r;
      rd_cos_r   <= sq_cos_r;
      rd_flags_r <= sq_flags_r;
    end
  end

  svang_sqrt #(
    .W    (RadW),
    .TagW (Sq2TagW)
  ) u_sqrt_sin (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (rd_vld_r),
    .in_rad   (rd_rad_r),
    .in_tag   ({rd_flags_r, rd_cos_r}),
    .out_vld  (sq2_vld),
    .out_root (sq2_root),
    .out_tag  (sq2_tag)
  );

  assign sq2_flags = flags_t'(sq2_tag[Sq2TagW-1 -: FlagsW]);
  assign sq2_cos   = sq2_tag[CosW-1:0];

  svang_cordic #(
    .TagW (FlagsW)
  ) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (sq2_vld),
    .in_cos  (sq2_cos),
    .in_sin  (sq2_root),
    .in_tag  (sq2_flags),
    .out_vld (cd_vld),
    .out_z   (cd_z),
    .out_tag (cd_flags)
  );

  // ---------------- clamp to [0, pi], fold for obtuse
  always_comb begin
    if (cd_z < 0) begin
      zc = '0;
    end else if (cd_z > $signed({2'b00, PI_Q16})) begin
      zc = PI_Q16;
    end else begin
      zc = cd_z[ZcW-1:0];
    end
    zf = cd_flags.neg_dot ? (PI_Q16 - zc) : zc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pz_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      pz_vld_r    <= cd_vld;
      out_valid_r <= pz_vld_r;
    end
  end

  // ---------------- round to Q3.12 and sign
  assign q_round = (ZcW+1)'(pz_z_r) + (ZcW+1)'(8);
  assign q_mag   = $signed(q_round[ZcW:4]);

  always_ff @(posedge clk) begin
    if (en) begin
      pz_z_r     <= zf;
      pz_flags_r <= cd_flags;
      out_zero_r <= pz_flags_r.zero;
      if (pz_flags_r.zero) begin
        out_angle_r <= '0;
      end else if (pz_flags_r.neg_tri) begin
        out_angle_r <= -q_mag;
      end else begin
        out_angle_r <= q_mag;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_angle       = out_angle_r;
  assign out_zero_length = out_zero_r;

`ifndef SYNTHESIS
  a_zero_gives_no_angle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_zero_r |-> out_angle_r == '0)
    else $error("zero-length transaction with non-zero angle");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_angle_r <= AngleMax) && (out_angle_r >= -AngleMax))
    else $error("angle outside +/- pi");

  a_sine_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sq2_vld && !sq2_flags.zero |-> sq2_root <= ONE_Q30)
    else $error("sine root above one");

  a_cos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> rd_cos_r <= ONE_Q30)
    else $error("cosine above one entering sine root");
`endif

endmodule

// File: test/signed_vector_angle_tb.sv
module signed_vector_angle_tb
  import svang_pkg::*;
;

  typedef struct {
    logic signed [CompW-1:0] v [9];
  } vec_set_t;

  typedef struct {
    logic signed [AngleW-1:0] angle;
    logic                     zero_length;
  } angle_res_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic signed [CompW-1:0] in_first_x, in_first_y, in_first_z;
  logic signed [CompW-1:0] in_second_x, in_second_y, in_second_z;
  logic signed [CompW-1:0] in_normal_x, in_normal_y, in_normal_z;
  logic out_valid;
  logic out_ready;
  logic signed [AngleW-1:0] out_angle;
  logic out_zero_length;

  vec_set_t   pending_sets [$];
  angle_res_t angle_queue [$];
  int         mismatches;
  bit         stim_done;
  bit         drain_hold;
  int         burst_left;
  int         gap_left;
  int         stall_phase;

  signed_vector_angle dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_first_x(in_first_x), .in_first_y(in_first_y), .in_first_z(in_first_z),
    .in_second_x(in_second_x), .in_second_y(in_second_y), .in_second_z(in_second_z),
    .in_normal_x(in_normal_x), .in_normal_y(in_normal_y), .in_normal_z(in_normal_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_angle(out_angle), .out_zero_length(out_zero_length)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned int_sqrt(longint unsigned val);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > val) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (val >= root + bitv) begin
        val = val - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic angle_res_t predict_angle(vec_set_t s);
    longint ax, ay, az, bx, by, bz, nx, ny, nz;
    longint dot, cx, cy, cz, tri_p, x, y, z, dx, dy, q;
    longint unsigned na, nb, prod, root, mag, c, sn;
    logic [127:0] num;
    int e;
    angle_res_t r;
    ax = s.v[0]; ay = s.v[1]; az = s.v[2];
    bx = s.v[3]; by = s.v[4]; bz = s.v[5];
    nx = s.v[6]; ny = s.v[7]; nz = s.v[8];
    na = ax*ax + ay*ay + az*az;
    nb = bx*bx + by*by + bz*bz;
    if (na == 0 || nb == 0) begin
      r.angle = '0;
      r.zero_length = 1'b1;
      return r;
    end
    dot = ax*bx + ay*by + az*bz;
    prod = na * nb;
    e = 0;
    while (prod < (64'd1 << 62)) begin
      prod = prod << 2;
      e++;
    end
    root = int_sqrt(prod);
    mag = dot < 0 ? -dot : dot;
    num = 128'(mag) << (30 + e);
    c = 64'((num + 128'(root >> 1)) / 128'(root));
    if (c > (64'd1 << 30)) c = 64'd1 << 30;
    sn = int_sqrt((64'd1 << 60) - c*c);
    x = c; y = sn; z = 0;
    for (int i = 0; i < CordSteps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += ATAN_TAB[i];
      end else begin
        x -= dx; y += dy; z -= ATAN_TAB[i];
      end
    end
    if (z < 0) z = 0;
    if (z > PI_Q16) z = PI_Q16;
    if (dot < 0) z = PI_Q16 - z;
    q = (z + 8) >>> 4;
    cx = ay*bz - az*by;
    cy = az*bx - ax*bz;
    cz = ax*by - ay*bx;
    tri_p = nx*cx + ny*cy + nz*cz;
    if (tri_p < 0) q = -q;
    r.angle = q[AngleW-1:0];
    r.zero_length = 1'b0;
    return r;
  endfunction

  function automatic logic signed [CompW-1:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'($signed($urandom_range(0, 8)) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_set(input int a0, a1, a2, b0, b1, b2, n0, n1, n2);
    vec_set_t s;
    s.v[0] = 16'(a0); s.v[1] = 16'(a1); s.v[2] = 16'(a2);
    s.v[3] = 16'(b0); s.v[4] = 16'(b1); s.v[5] = 16'(b2);
    s.v[6] = 16'(n0); s.v[7] = 16'(n1); s.v[8] = 16'(n2);
    pending_sets.push_back(s);
  endtask

  task automatic add_random(input int kind);
    vec_set_t s;
    int k;
    int base;
    for (int i = 0; i < 9; i++) s.v[i] = rand_comp();
    case (kind)
      0: begin
        k = $urandom_range(0, 2) == 0 ? -1 : 1;
        for (int i = 0; i < 3; i++) s.v[3+i] = 16'(k * s.v[i] / 2);
      end
      1: begin
        base = 3 * $urandom_range(0, 1);
        for (int i = 0; i < 3; i++) s.v[base+i] = '0;
      end
      2: for (int i = 6; i < 9; i++) s.v[i] = '0;
      default: ;
    endcase
    pending_sets.push_back(s);
  endtask

  initial begin
    rst_n = 0;
    stim_done = 0;
    drain_hold = 0;
    mismatches = 0;
    add_set(0, 0, 0, 4096, 0, 0, 0, 0, 4096);
    add_set(4096, 0, 0, 0, 0, 0, 0, 0, 4096);
    add_set(0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_set(4096, 0, 0, 4096, 0, 0, 0, 0, 4096);
    add_set(4096, 0, 0, -4096, 0, 0, 0, 0, 4096);
    add_set(4096, 0, 0, 0, 4096, 0, 0, 0, 4096);
    add_set(4096, 0, 0, 0, 4096, 0, 0, 0, -4096);
    add_set(4096, 0, 0, 0, 4096, 0, 0, 0, 0);
    add_set(4096, 0, 0, 0, 4096, 0, 4096, 0, 0);
    add_set(-32768, -32768, -32768, 32767, 32767, 32767, -32768, -32768, -32768);
    add_set(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
    add_set(-32768, -32768, -32768, -32768, -32768, -32768, 1, 1, 1);
    add_set(1, 0, 0, 0, 0, 1, 0, -1, 0);
    add_set(1, 0, 0, 1, 1, 0, 0, 0, -32768);
    add_set(-32768, 32767, 1, -1, 2, -32768, 32767, -32768, 5);
    add_set(3, 4, 0, -4, 3, 0, 0, 0, 1);
    add_set(32767, 0, 0, 32767, 1, 0, 0, 0, 1);
    add_set(1, 0, 0, -32768, 1, 0, 0, 0, -1);
    for (int i = 0; i < 630; i++) add_random($urandom_range(0, 6));
    repeat (11) @(posedge clk);
    rst_n <= 1;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
      {in_first_x, in_first_y, in_first_z} <= '0;
      {in_second_x, in_second_y, in_second_z} <= '0;
      {in_normal_x, in_normal_y, in_normal_z} <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) angle_queue.push_back(predict_angle(pending_sets.pop_front()));
      if (pending_sets.size() == 320 && !drain_hold && in_valid) drain_hold <= 1;
      if (drain_hold && angle_queue.size() == 0 && !in_valid) drain_hold <= 0;
      if (pending_sets.size() == 0 || drain_hold ||
          (pending_sets.size() == 320 && in_valid && !drain_hold)) begin
        in_valid <= 0;
        if (pending_sets.size() == 0) stim_done <= 1;
      end else if (gap_left > 0) begin
        in_valid <= 0;
        gap_left <= gap_left - 1;
      end else begin
        in_valid <= 1;
        in_first_x  <= pending_sets[0].v[0];
        in_first_y  <= pending_sets[0].v[1];
        in_first_z  <= pending_sets[0].v[2];
        in_second_x <= pending_sets[0].v[3];
        in_second_y <= pending_sets[0].v[4];
        in_second_z <= pending_sets[0].v[5];
        in_normal_x <= pending_sets[0].v[6];
        in_normal_y <= pending_sets[0].v[7];
        in_normal_z <= pending_sets[0].v[8];
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(0, 40);
          gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 0;
      stall_phase <= 0;
    end else begin
      stall_phase <= (stall_phase + 1) % 300;
      if (stall_phase < 100) out_ready <= 1;
      else if (stall_phase < 200) out_ready <= ($urandom_range(0, 3) != 0);
      else out_ready <= ($urandom_range(0, 2) == 0);
      if (out_valid && out_ready) begin
        if (angle_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transaction: angle %0d zero %0b",
                                         out_angle, out_zero_length);
        end else begin
          angle_res_t exp_r;
          exp_r = angle_queue.pop_front();
          if (exp_r.angle !== out_angle || exp_r.zero_length !== out_zero_length) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: angle exp %0d got %0d, zero exp %0b got %0b",
                       exp_r.angle, out_angle, exp_r.zero_length, out_zero_length);
          end
        end
      end
    end
  end

  initial begin
    wait (stim_done);
    wait (angle_queue.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && angle_queue.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #5000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// File: files.f
src/svang_pkg.sv
src/svang_sqrt.sv
src/svang_div.sv
src/svang_cordic.sv
src/signed_vector_angle.sv
test/signed_vector_angle_tb.sv
